// ===== hw/rtl/mme_pkg.sv =====
package mme_pkg;

    // Sizing
    localparam int MAX_DIM     = 8;
    localparam int DATA_WIDTH  = 16;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int CNT_W       = 2 * DIM_W;
    localparam int PROD_W      = 2 * DATA_WIDTH;

    // Fixed field widths
    localparam int CFG_W      = 4;
    localparam int OPC_W      = 2;
    localparam int ELEM_IDX_W = 6;
    localparam int ELEM_W     = 16;
    localparam int RESULT_W   = 36;
    localparam int POS_W      = 3;
    localparam int CMP_W      = (CNT_W > ELEM_IDX_W) ? CNT_W : ELEM_IDX_W;

    // Register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        REG_ROW_COUNT    = 2'd0,
        REG_COLUMN_COUNT = 2'd1,
        REG_INNER_COUNT  = 2'd2
    } t_reg_index;

    // Travels alongside each product through the pipe
    typedef struct packed {
        logic             first_k;
        logic             last_k;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    // Zero acts as one, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (int'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

endpackage

// ===== hw/rtl/mme_ram.sv =====
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/mme_mac.sv =====
module mme_mac import mme_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic                       i_valid,
    input  t_tag                       i_tag,
    input  logic [DATA_WIDTH-1:0]      i_a,
    input  logic [DATA_WIDTH-1:0]      i_b,
    input  logic signed [RESULT_W-1:0] i_tap,
    output logic                       o_valid,
    output t_tag                       o_tag,
    output logic signed [RESULT_W-1:0] o_sum
);

    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_valid;
    t_tag                       r_tag;
    logic signed [RESULT_W-1:0] w_prod_ext;
    logic signed [RESULT_W-1:0] w_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_prod <= $signed(i_a) * $signed(i_b);
            r_tag  <= i_tag;
        end
    end

    // first inner step starts a fresh sum, later steps add to the recirculated one
    always_comb begin
        w_prod_ext = RESULT_W'(r_prod);
        w_base     = r_tag.first_k ? '0 : i_tap;
        o_sum      = w_prod_ext + w_base;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;

endmodule

// ===== hw/rtl/mme_cell.sv =====
module mme_cell import mme_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic signed [RESULT_W-1:0] i_sum,
    output logic signed [RESULT_W-1:0] o_sum
);

    // one partial sum of the current result row
    logic signed [RESULT_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sum <= i_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== hw/rtl/matrix_multiply_engine.sv =====
// Loads give no result; a new item is taken every cycle while idle.
// A compute item busies the block while it issues rows*inner*columns products (one product per cycle
// unless the output stalls, through one read port of each store); results arrive one per cycle,
// unless the output stalls, in the last inner step of each row.
// Reset (synchronous, active low) sets all size registers to 8 and empties the pipe;
// the element stores are not cleared and hold garbage until written.
module matrix_multiply_engine import mme_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // item input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [OPC_W-1:0]             i_opcode,
    input  logic [ELEM_IDX_W-1:0]        i_element_index,
    input  logic signed [ELEM_W-1:0]     i_element_value,

    // result output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [RESULT_W-1:0]   o_result_value,
    output logic [POS_W-1:0]             o_result_row,
    output logic [POS_W-1:0]             o_result_column,
    output logic                         o_last_result,

    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;

    // size registers, raw as written
    logic [CFG_W-1:0] r_row_count;
    logic [CFG_W-1:0] r_column_count;
    logic [CFG_W-1:0] r_inner_count;

    // sizes latched for the running compute
    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;
    logic [DIM_W-1:0] r_inner;

    // walk counters: row i, inner k, column j.
    // Loop order is i, k, j so the B address simply counts up within a row.
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_k;
    logic [IDX_W-1:0]  r_j;
    logic [ADDR_W-1:0] r_p;
    logic [ADDR_W-1:0] r_a_base;

    // stage 1: store read data registered in the RAMs
    logic r_s1_valid;
    t_tag r_s1_tag;

    // output register
    logic                       r_out_valid;
    logic signed [RESULT_W-1:0] r_out_value;
    logic [POS_W-1:0]           r_out_row;
    logic [POS_W-1:0]           r_out_col;
    logic                       r_out_last;

    logic                       w_adv;
    logic                       w_in_acc;
    logic                       w_cfg_wr;
    t_opcode                    w_op;
    t_reg_index                 w_reg_idx;
    logic [DIM_W-1:0]           w_rows_c;
    logic [DIM_W-1:0]           w_cols_c;
    logic [DIM_W-1:0]           w_inner_c;
    logic [CMP_W-1:0]           w_idx_ext;
    logic [CMP_W-1:0]           w_a_limit;
    logic [CMP_W-1:0]           w_b_limit;
    logic                       w_idx_in_store;
    logic                       w_we_a;
    logic                       w_we_b;
    logic                       w_start;
    logic [ADDR_W-1:0]          w_wr_addr;
    logic [DATA_WIDTH-1:0]      w_wr_data;
    logic [ADDR_W-1:0]          w_a_addr;
    logic [IDX_W-1:0]           w_rows_m1;
    logic [IDX_W-1:0]           w_cols_m1;
    logic [IDX_W-1:0]           w_inner_m1;
    logic                       w_i_end;
    logic                       w_k_end;
    logic                       w_j_end;
    t_tag                       w_issue_tag;
    logic [DATA_WIDTH-1:0]      w_a_data;
    logic [DATA_WIDTH-1:0]      w_b_data;
    logic                       w_mac_valid;
    t_tag                       w_mac_tag;
    logic signed [RESULT_W-1:0] w_mac_sum;
    logic signed [RESULT_W-1:0] w_tap;
    logic                       w_shift;
    logic                       w_emit;
    logic signed [RESULT_W-1:0] w_chain [MAX_DIM];

    // The whole pipe moves unless a result sits in the output register and is stalled.
    assign w_adv      = !(r_out_valid && i_out_stall);
    assign o_in_stall = (r_state == ST_RUN);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_reg_idx  = t_reg_index'(paddr[APB_ADDR_W-1:2]);
    assign pready     = 1'b1;

    always_comb begin
        unique case (w_reg_idx)
            REG_ROW_COUNT:    prdata = APB_DATA_W'(r_row_count);
            REG_COLUMN_COUNT: prdata = APB_DATA_W'(r_column_count);
            REG_INNER_COUNT:  prdata = APB_DATA_W'(r_inner_count);
            default:          prdata = '0;
        endcase
    end

    // Load decode: index must fall inside the active matrix size
    always_comb begin
        w_op           = t_opcode'(i_opcode);
        w_rows_c       = clamp_dim(r_row_count);
        w_cols_c       = clamp_dim(r_column_count);
        w_inner_c      = clamp_dim(r_inner_count);
        w_idx_ext      = CMP_W'(i_element_index);
        w_a_limit      = CMP_W'(CNT_W'(w_rows_c) * CNT_W'(w_inner_c));
        w_b_limit      = CMP_W'(CNT_W'(w_inner_c) * CNT_W'(w_cols_c));
        w_idx_in_store = (w_idx_ext < CMP_W'(STORE_DEPTH));
        w_we_a         = w_in_acc && (w_op == OP_LOAD_A) && w_idx_in_store
                         && (w_idx_ext < w_a_limit);
        w_we_b         = w_in_acc && (w_op == OP_LOAD_B) && w_idx_in_store
                         && (w_idx_ext < w_b_limit);
        w_start        = w_in_acc && (w_op == OP_COMPUTE);
        w_wr_addr      = ADDR_W'(i_element_index);
        w_wr_data      = DATA_WIDTH'(i_element_value);
    end

    // Issue stage: address of A(i,k) and B(k,j), plus the tag for this product
    always_comb begin
        w_rows_m1          = IDX_W'(r_rows - DIM_W'(1));
        w_cols_m1          = IDX_W'(r_cols - DIM_W'(1));
        w_inner_m1         = IDX_W'(r_inner - DIM_W'(1));
        w_i_end            = (r_i == w_rows_m1);
        w_k_end            = (r_k == w_inner_m1);
        w_j_end            = (r_j == w_cols_m1);
        w_a_addr           = r_a_base + ADDR_W'(r_k);
        w_issue_tag.first_k = (r_k == '0);
        w_issue_tag.last_k  = w_k_end;
        w_issue_tag.last    = w_i_end && w_k_end && w_j_end;
        w_issue_tag.row     = r_i;
        w_issue_tag.col     = r_j;
    end

    mme_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_we_a),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_a_addr),
        .o_rd_data (w_a_data)
    );

    mme_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_we_b),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_adv),
        .i_rd_addr (r_p),
        .o_rd_data (w_b_data)
    );

    // Stage 2: product register and the head adder
    mme_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_adv),
        .i_valid   (r_s1_valid),
        .i_tag     (r_s1_tag),
        .i_a       (w_a_data),
        .i_b       (w_b_data),
        .i_tap     (w_tap),
        .o_valid   (w_mac_valid),
        .o_tag     (w_mac_tag),
        .o_sum     (w_mac_sum)
    );

    // Chain of partial sums. Each new sum enters cell 0 and moves one cell per
    // product; after 'columns' products the sum for the same column reaches the
    // tap at cell columns-1, just as the next inner step for that column arrives.
    assign w_shift = w_adv && w_mac_valid;
    assign w_tap   = w_chain[w_cols_m1];
    assign w_emit  = w_mac_valid && w_mac_tag.last_k;

    for (genvar c = 0; c < MAX_DIM; c++) begin : g_chain
        if (c == 0) begin : g_head
            mme_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_sum   (w_mac_sum),
                .o_sum   (w_chain[c])
            );
        end else begin : g_body
            mme_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_sum   (w_chain[c-1]),
                .o_sum   (w_chain[c])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_row_count    <= CFG_RESET;
            r_column_count <= CFG_RESET;
            r_inner_count  <= CFG_RESET;
        end else begin
            if (w_cfg_wr) begin
                unique case (w_reg_idx)
                    REG_ROW_COUNT:    r_row_count    <= pwdata[CFG_W-1:0];
                    REG_COLUMN_COUNT: r_column_count <= pwdata[CFG_W-1:0];
                    REG_INNER_COUNT:  r_inner_count  <= pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        r_state  <= ST_RUN;
                        r_rows   <= w_rows_c;
                        r_cols   <= w_cols_c;
                        r_inner  <= w_inner_c;
                        r_i      <= '0;
                        r_k      <= '0;
                        r_j      <= '0;
                        r_p      <= '0;
                        r_a_base <= '0;
                    end
                end
                ST_RUN: begin
                    if (w_adv) begin
                        if (w_j_end) begin
                            r_j <= '0;
                            if (w_k_end) begin
                                r_k      <= '0;
                                r_p      <= '0;
                                r_i      <= r_i + IDX_W'(1);
                                r_a_base <= r_a_base + ADDR_W'(r_inner);
                                if (w_i_end) begin
                                    r_state <= ST_IDLE;
                                end
                            end else begin
                                r_k <= r_k + IDX_W'(1);
                                r_p <= r_p + ADDR_W'(1);
                            end
                        end else begin
                            r_j <= r_j + IDX_W'(1);
                            r_p <= r_p + ADDR_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (w_adv) begin
                r_s1_valid  <= (r_state == ST_RUN);
                r_s1_tag    <= w_issue_tag;
                r_out_valid <= w_emit;
                if (w_emit) begin
                    r_out_value <= w_mac_sum;
                    r_out_row   <= POS_W'(w_mac_tag.row);
                    r_out_col   <= POS_W'(w_mac_tag.col);
                    r_out_last  <= w_mac_tag.last;
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_out_value;
    assign o_result_row    = r_out_row;
    assign o_result_column = r_out_col;
    assign o_last_result   = r_out_last;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mme_pkg::*;

    // Opcode the block must ignore; not a member of t_opcode
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 55;
    localparam int IDLE_PCT      = 18;
    // Settle time once the last result is out; covers the pipe tail
    localparam int SETTLE_CYCLES = 16;
    // Hard time limit in ns, far beyond the slowest correct run
    localparam int RUN_LIMIT_NS  = 10_000_000;

    // One element of the product matrix as it should leave the block
    typedef struct {
        logic signed [RESULT_W-1:0] value;
        logic [POS_W-1:0]           row;
        logic [POS_W-1:0]           column;
        logic                       last;
    } t_product;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [OPC_W-1:0]           i_opcode;
    logic [ELEM_IDX_W-1:0]      i_element_index;
    logic signed [ELEM_W-1:0]   i_element_value;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [RESULT_W-1:0] o_result_value;
    logic [POS_W-1:0]           o_result_row;
    logic [POS_W-1:0]           o_result_column;
    logic                       o_last_result;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]      pwdata;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;

    // Shadow of the block: both element stores, which entries hold
    // real data, and the three size registers as written.
    logic signed [ELEM_W-1:0] a_elems [STORE_DEPTH];
    logic signed [ELEM_W-1:0] b_elems [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]   a_loaded;
    logic [STORE_DEPTH-1:0]   b_loaded;
    logic [CFG_W-1:0]         rows_reg;
    logic [CFG_W-1:0]         cols_reg;
    logic [CFG_W-1:0]         inner_reg;

    // Product elements predicted but not yet seen, oldest first
    t_product pending_products[$];

    int  error_count     = 0;
    int  items_sent      = 0;
    int  compute_count   = 0;
    int  results_checked = 0;
    bit  no_idle         = 1'b0;

    matrix_multiply_engine u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_value  (o_result_value),
        .o_result_row    (o_result_row),
        .o_result_column (o_result_column),
        .o_last_result   (o_last_result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("testbench: done, errors");
        $finish;
    end

    // Effective size: zero acts as one, anything above MAX_DIM as MAX_DIM
    function automatic int active_dim(input logic [CFG_W-1:0] setting);
        if (setting == '0) begin
            return 1;
        end
        if (int'(setting) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(setting);
    endfunction

    // Push every element of A * B under the sizes active right now
    function automatic void queue_product_matrix();
        int rows;
        int cols;
        int inner;
        logic signed [RESULT_W-1:0] acc;
        logic signed [2*ELEM_W-1:0] prod;
        t_product elem;
        rows  = active_dim(rows_reg);
        cols  = active_dim(cols_reg);
        inner = active_dim(inner_reg);
        for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
                acc = '0;
                for (int k = 0; k < inner; k++) begin
                    prod = a_elems[i * inner + k] * b_elems[k * cols + j];
                    acc  = acc + prod;  // sign-extends, wraps at 36 bits
                end
                elem.value  = acc;
                elem.row    = POS_W'(i);
                elem.column = POS_W'(j);
                elem.last   = (i == rows - 1) && (j == cols - 1);
                pending_products.push_back(elem);
            end
        end
    endfunction

    // Apply one accepted item to the shadow state
    function automatic void absorb_item(input logic [OPC_W-1:0] op,
                                        input logic [ELEM_IDX_W-1:0] idx,
                                        input logic [ELEM_W-1:0] val);
        int rows;
        int cols;
        int inner;
        rows  = active_dim(rows_reg);
        cols  = active_dim(cols_reg);
        inner = active_dim(inner_reg);
        case (op)
            OP_LOAD_A: begin
                // loads past the active A size are dropped
                if (int'(idx) < rows * inner) begin
                    a_elems[idx]  = val;
                    a_loaded[idx] = 1'b1;
                end
            end
            OP_LOAD_B: begin
                if (int'(idx) < inner * cols) begin
                    b_elems[idx]  = val;
                    b_loaded[idx] = 1'b1;
                end
            end
            OP_COMPUTE: begin
                queue_product_matrix();
                compute_count++;
            end
            default: begin
                // unused opcode: no effect
            end
        endcase
    endfunction

    // Element values lean on the extremes of Q8.8
    function automatic logic [ELEM_W-1:0] rand_element();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return ELEM_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Size register setting: mostly small, sometimes zero, full or over range
    function automatic logic [CFG_W-1:0] rand_size_setting();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return CFG_W'($urandom_range(MAX_DIM + 1, 15));
            2: return CFG_W'(MAX_DIM);
            default: return CFG_W'($urandom_range(1, 3));
        endcase
    endfunction

    // Called at a rising edge; returns at the edge that takes the item.
    // Valid stays high on return so back-to-back items carry no bubble.
    task automatic send_item(input logic [OPC_W-1:0] op,
                             input logic [ELEM_IDX_W-1:0] idx,
                             input logic [ELEM_W-1:0] val);
        while (!no_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_element_index <= idx;
        i_element_value <= val;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        absorb_item(op, idx, val);
        items_sent++;
    endtask

    // Drop valid and let every predicted element drain out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_products.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, then access phase; pready is tied high
    task automatic reg_write(input t_reg_index which, input logic [CFG_W-1:0] setting);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= APB_DATA_W'(setting);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        case (which)
            REG_ROW_COUNT:    rows_reg  = setting;
            REG_COLUMN_COUNT: cols_reg  = setting;
            default:          inner_reg = setting;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(input logic [CFG_W-1:0] rows,
                             input logic [CFG_W-1:0] cols,
                             input logic [CFG_W-1:0] inner);
        reg_write(REG_ROW_COUNT, rows);
        reg_write(REG_COLUMN_COUNT, cols);
        reg_write(REG_INNER_COUNT, inner);
    endtask

    // Stores are undefined after reset, so fill every entry the next
    // compute will read that has never been written.
    task automatic ensure_loaded();
        int a_span;
        int b_span;
        a_span = active_dim(rows_reg) * active_dim(inner_reg);
        b_span = active_dim(inner_reg) * active_dim(cols_reg);
        for (int i = 0; i < a_span; i++) begin
            if (!a_loaded[i]) begin
                send_item(OP_LOAD_A, ELEM_IDX_W'(i), rand_element());
            end
        end
        for (int i = 0; i < b_span; i++) begin
            if (!b_loaded[i]) begin
                send_item(OP_LOAD_B, ELEM_IDX_W'(i), rand_element());
            end
        end
    endtask

    // 1x1x1 products at the corners of Q8.8: largest positive sum,
    // most negative, and max times max.
    task automatic test_single_element_extremes();
        set_sizes(4'd1, 4'd1, 4'd1);
        send_item(OP_LOAD_A, '0, 16'h8000);
        send_item(OP_LOAD_B, '0, 16'h8000);
        send_item(OP_COMPUTE, '0, '0);
        send_item(OP_LOAD_A, '0, 16'h7FFF);
        send_item(OP_COMPUTE, 6'h3F, 16'hFFFF);
        send_item(OP_LOAD_B, '0, 16'h7FFF);
        send_item(OP_COMPUTE, '0, '0);
        wait_idle();
    endtask

    // Out-of-size loads and the unused opcode must leave the stores alone
    task automatic test_ignored_items();
        send_item(OP_LOAD_A, 6'd1, 16'h1234);
        send_item(OP_LOAD_B, 6'h3F, 16'h8001);
        send_item(OP_UNUSED, '0, 16'h5555);
        send_item(OP_UNUSED, 6'h3F, 16'hAAAA);
        send_item(OP_COMPUTE, '0, '0);
        wait_idle();
    endtask

    // Zero acts as one and values above MAX_DIM as MAX_DIM: a 1x8 row
    // of results from a 1x1 A and 1x8 B.
    task automatic test_size_clamping();
        set_sizes(4'd0, 4'd15, 4'd0);
        ensure_loaded();
        send_item(OP_COMPUTE, '0, '0);
        wait_idle();
    endtask

    // Largest result matrix, 8x8 over an inner size of two, with no idling
    // on either side; a second compute follows back to back.
    task automatic test_full_size_burst();
        no_idle = 1'b1;
        set_sizes(CFG_W'(MAX_DIM), CFG_W'(MAX_DIM), 4'd2);
        for (int i = 0; i < 2 * MAX_DIM; i++) begin
            send_item(OP_LOAD_A, ELEM_IDX_W'(i), rand_element());
        end
        for (int i = 0; i < 2 * MAX_DIM; i++) begin
            send_item(OP_LOAD_B, ELEM_IDX_W'(i), rand_element());
        end
        send_item(OP_COMPUTE, '0, '0);
        send_item(OP_COMPUTE, ELEM_IDX_W'($urandom_range(0, 63)), rand_element());
        wait_idle();
        no_idle = 1'b0;
    endtask

    // Load-then-compute sequences under fresh sizes, with about one item
    // in ten being noise. Stores carry over between sequences, so a
    // compute often reads data loaded under other sizes.
    task automatic test_random_sequences();
        int base;
        int a_span;
        int b_span;
        int pick;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            wait_idle();
            set_sizes(rand_size_setting(), rand_size_setting(), rand_size_setting());
            a_span = active_dim(rows_reg) * active_dim(inner_reg);
            b_span = active_dim(inner_reg) * active_dim(cols_reg);
            for (int n = 0; n < a_span + b_span; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    pick = $urandom_range(0, 2);
                    if (pick == 0 && a_span < STORE_DEPTH) begin
                        send_item(OP_LOAD_A,
                                  ELEM_IDX_W'($urandom_range(a_span, STORE_DEPTH - 1)),
                                  rand_element());
                    end else if (pick == 1 && b_span < STORE_DEPTH) begin
                        send_item(OP_LOAD_B,
                                  ELEM_IDX_W'($urandom_range(b_span, STORE_DEPTH - 1)),
                                  rand_element());
                    end else begin
                        send_item(OP_UNUSED, ELEM_IDX_W'($urandom_range(0, 63)),
                                  rand_element());
                    end
                end else if ($urandom_range(0, 1) == 0) begin
                    send_item(OP_LOAD_A, ELEM_IDX_W'($urandom_range(0, a_span - 1)),
                              rand_element());
                end else begin
                    send_item(OP_LOAD_B, ELEM_IDX_W'($urandom_range(0, b_span - 1)),
                              rand_element());
                end
            end
            ensure_loaded();
            send_item(OP_COMPUTE, ELEM_IDX_W'($urandom_range(0, 63)), rand_element());
            if ($urandom_range(0, 3) == 0) begin
                send_item(OP_COMPUTE, ELEM_IDX_W'($urandom_range(0, 63)), rand_element());
            end
        end
        wait_idle();
    endtask

    // Result side stalls at random unless a no-idle stretch is running
    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Every result taken is matched against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_product want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_products.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing expected: value %0d row %0d col %0d",
                         $time, o_result_value, o_result_row, o_result_column);
            end else begin
                want = pending_products.pop_front();
                results_checked++;
                if (o_result_value !== want.value) begin
                    error_count++;
                    $display("%0t: value at (%0d,%0d) expected %0d, got %0d", $time,
                             want.row, want.column, want.value, o_result_value);
                end
                if (o_result_row !== want.row) begin
                    error_count++;
                    $display("%0t: row expected %0d, got %0d", $time,
                             want.row, o_result_row);
                end
                if (o_result_column !== want.column) begin
                    error_count++;
                    $display("%0t: column expected %0d, got %0d", $time,
                             want.column, o_result_column);
                end
                if (o_last_result !== want.last) begin
                    error_count++;
                    $display("%0t: last flag at (%0d,%0d) expected %0b, got %0b", $time,
                             want.row, want.column, want.last, o_last_result);
                end
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_opcode        <= OP_LOAD_A;
        i_element_index <= '0;
        i_element_value <= '0;
        i_out_stall     <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        a_loaded         = '0;
        b_loaded         = '0;
        rows_reg         = CFG_RESET;
        cols_reg         = CFG_RESET;
        inner_reg        = CFG_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_element_extremes();
        test_ignored_items();
        test_size_clamping();
        test_full_size_burst();
        test_random_sequences();

        wait_idle();
        $display("testbench: %0d items taken, %0d computes, %0d result elements compared",
                 items_sent, compute_count, results_checked);
        $display("testbench: sizes 1..8 incl. zero and over-range settings, ignored loads");
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
